// ===== rtl/core/pst_pkg.sv =====
// Package for the packet statistics top talker core.
// Holds payload structs, table sizing, protocol codes and control types.
// Used by every module under rtl/core except pst_ram.
package pst_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int HEADER_BYTES = 54;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam int SYN_BIT = 1;

  localparam logic [15:0] WEB_PORT_FIRST_RESET = 16'd80;
  localparam logic [15:0] WEB_PORT_SECOND_RESET = 16'd443;
  localparam logic [15:0] NAME_SERVICE_PORT_RESET = 16'd53;

  typedef enum logic [1:0] {
    CFG_WEB_PORT_FIRST = 2'd0,
    CFG_WEB_PORT_SECOND = 2'd1,
    CFG_NAME_SERVICE_PORT = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] frame_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] frame_length;
  } in_item_t;

  typedef struct packed {
    logic [31:0] icmp_total;
    logic [31:0] tcp_total;
    logic [31:0] udp_total;
    logic [31:0] dns_total;
    logic [31:0] top_syn_addr;
    logic [31:0] top_syn_count;
    logic        top_syn_valid;
    logic [31:0] top_web_addr;
    logic [31:0] top_web_bytes;
    logic        top_web_valid;
    logic        table_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_WRITE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic upd_write;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic syn_done;
    logic web_done;
    logic out_free;
  } ctrl_status_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [31:0] value;
    logic        overflow;
  } tbl_result_t;

endpackage

// ===== rtl/core/packet_stats_top_talker_core.sv =====
// Sequence: a request is accepted in IDLE, both table scans run in SCAN, the value memory
// read completes in READ, the update is written in WRITE and the result is loaded from FINISH.
// A new request is taken only once the last result has been loaded into the output register;
// a stalled result holds the next one in FINISH.
// Reset: synchronous; clears counters, fill counts and configuration to defaults;
// table memories are not cleared and entries beyond the fill count are never read.
module packet_stats_top_talker_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pst_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  pst_pkg::ctrl_cmd_t    cmd;
  pst_pkg::ctrl_status_t status;
  pst_pkg::tbl_result_t  syn_res;
  pst_pkg::tbl_result_t  web_res;
  logic                  syn_req;
  logic                  web_req;
  logic [31:0]           syn_key;
  logic [31:0]           web_key;
  logic [31:0]           syn_amount;
  logic [31:0]           web_amount;
  logic                  syn_done;
  logic                  web_done;
  logic                  out_free;

  // Status gathered for the controller.
  always_comb begin
    status.in_valid = in_valid;
    status.syn_done = syn_done;
    status.web_done = web_done;
    status.out_free = out_free;
  end

  pst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .status(status), .cmd(cmd), .in_ready(in_ready)
  );

  pst_stats u_stats (
    .clk(clk), .rst(rst), .cmd(cmd), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cfg_ready(cfg_ready), .syn_res(syn_res), .web_res(web_res),
    .syn_req(syn_req), .web_req(web_req), .syn_key(syn_key), .web_key(web_key),
    .syn_amount(syn_amount), .web_amount(web_amount),
    .out_ready(out_ready), .out_valid(out_valid), .out_data(out_data),
    .out_free(out_free)
  );

  pst_table u_syn_table (
    .clk(clk), .rst(rst), .cmd(cmd), .req(syn_req), .key(syn_key),
    .amount(syn_amount), .done(syn_done), .result(syn_res)
  );

  pst_table u_web_table (
    .clk(clk), .rst(rst), .cmd(cmd), .req(web_req), .key(web_key),
    .amount(web_amount), .done(web_done), .result(web_res)
  );

endmodule

// ===== rtl/core/pst_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pst_table.sv =====
// Address table datapath: find-or-insert scan, saturating update, leader tracking.
// Depends on pst_pkg and pst_ram.
module pst_table (
  input  logic                clk,
  input  logic                rst,
  input  pst_pkg::ctrl_cmd_t  cmd,
  input  logic                req,
  input  logic [31:0]         key,
  input  logic [31:0]         amount,
  output logic                done,
  output pst_pkg::tbl_result_t result
);

  localparam logic [pst_pkg::CNT_W-1:0] FULL = pst_pkg::CNT_W'(pst_pkg::TABLE_ENTRIES);

  logic                       active;
  logic [31:0]                key_q;
  logic [31:0]                amount_q;
  logic [pst_pkg::CNT_W-1:0]  used;
  logic [pst_pkg::CNT_W-1:0]  k;
  logic                       pend;
  logic [pst_pkg::IDX_W-1:0]  pk;
  logic                       found;
  logic [pst_pkg::IDX_W-1:0]  fidx;
  logic                       done_q;
  logic                       overflow;
  logic [pst_pkg::IDX_W-1:0]  top_idx;
  logic [31:0]                top_addr;
  logic [31:0]                top_val;

  logic [31:0]                addr_rdata;
  logic [31:0]                val_rdata;
  logic                       issue;
  logic                       hit;
  logic                       last;
  logic                       ins;
  logic                       upd;
  logic [32:0]                sum;
  logic [31:0]                newval;
  logic [pst_pkg::IDX_W-1:0]  widx;
  logic                       take_top;

  pst_ram #(.WIDTH(32), .DEPTH(pst_pkg::TABLE_ENTRIES)) u_addr_ram (
    .clk(clk), .we(ins), .waddr(widx), .wdata(key_q),
    .raddr(k[pst_pkg::IDX_W-1:0]), .rdata(addr_rdata)
  );

  pst_ram #(.WIDTH(32), .DEPTH(pst_pkg::TABLE_ENTRIES)) u_val_ram (
    .clk(clk), .we(upd), .waddr(widx), .wdata(newval),
    .raddr(fidx), .rdata(val_rdata)
  );

  // Scan compare and update arithmetic.
  always_comb begin
    issue = cmd.scan && !done_q && (k < used);
    hit = cmd.scan && pend && !done_q && (addr_rdata == key_q);
    last = pend && ({1'b0, pk} == used - 1'b1);
    ins = cmd.upd_write && active && !found && (used != FULL);
    upd = cmd.upd_write && active && (found || (used != FULL));
    sum = {1'b0, val_rdata} + {1'b0, amount_q};
    if (found) begin
      newval = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      widx = fidx;
    end else begin
      newval = amount_q;
      widx = used[pst_pkg::IDX_W-1:0];
    end
    take_top = (used == '0) || (widx == top_idx) || (newval > top_val) ||
               ((newval == top_val) && (widx < top_idx));
  end

  // Control state of the scan and the fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      used <= '0;
      k <= '0;
      pend <= 1'b0;
      found <= 1'b0;
      done_q <= 1'b1;
      overflow <= 1'b0;
      top_idx <= '0;
    end else begin
      if (cmd.start) begin
        active <= req;
        k <= '0;
        pend <= 1'b0;
        found <= 1'b0;
        overflow <= 1'b0;
        done_q <= !req || (used == '0);
      end else if (cmd.scan) begin
        pend <= issue;
        if (issue) begin
          k <= k + 1'b1;
        end
        if (hit) begin
          found <= 1'b1;
          done_q <= 1'b1;
        end else if (!done_q && last) begin
          done_q <= 1'b1;
        end
      end
      if (cmd.upd_write) begin
        if (ins) begin
          used <= used + 1'b1;
        end
        if (active && !found && (used == FULL)) begin
          overflow <= 1'b1;
        end
        if (upd && take_top) begin
          top_idx <= widx;
        end
      end
    end
  end

  // Payload registers of the request and the leader.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_q <= key;
      amount_q <= amount;
    end
    if (issue) begin
      pk <= k[pst_pkg::IDX_W-1:0];
    end
    if (hit) begin
      fidx <= pk;
    end
    if (upd && take_top) begin
      top_addr <= key_q;
      top_val <= newval;
    end
  end

  // Leader is reported as zero while the table is empty.
  always_comb begin
    done = done_q;
    result.valid = (used != '0);
    result.addr = result.valid ? top_addr : 32'd0;
    result.value = result.valid ? top_val : 32'd0;
    result.overflow = overflow;
  end

endmodule

// ===== rtl/core/pst_stats.sv =====
// Statistics datapath: configuration registers, protocol counters, table
// requests and the output register. Depends on pst_pkg.
module pst_stats (
  input  logic                 clk,
  input  logic                 rst,
  input  pst_pkg::ctrl_cmd_t   cmd,
  input  pst_pkg::in_item_t    in_data,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  output logic                 cfg_ready,
  input  pst_pkg::tbl_result_t syn_res,
  input  pst_pkg::tbl_result_t web_res,
  output logic                 syn_req,
  output logic                 web_req,
  output logic [31:0]          syn_key,
  output logic [31:0]          web_key,
  output logic [31:0]          syn_amount,
  output logic [31:0]          web_amount,
  input  logic                 out_ready,
  output logic                 out_valid,
  output pst_pkg::out_item_t   out_data,
  output logic                 out_free
);

  logic [15:0] web_port_first;
  logic [15:0] web_port_second;
  logic [15:0] name_service_port;
  logic [31:0] icmp_cnt;
  logic [31:0] tcp_cnt;
  logic [31:0] udp_cnt;
  logic [31:0] dns_cnt;

  logic        is_ipv4;
  logic        is_tcp;
  logic        is_udp;
  logic        is_icmp;
  logic        is_dns;
  logic        is_web;

  // Classification of the incoming request.
  always_comb begin
    is_ipv4 = (in_data.frame_type == pst_pkg::ETHERTYPE_IPV4);
    is_tcp = is_ipv4 && (in_data.ip_protocol == pst_pkg::PROTO_TCP);
    is_udp = is_ipv4 && (in_data.ip_protocol == pst_pkg::PROTO_UDP);
    is_icmp = is_ipv4 && (in_data.ip_protocol == pst_pkg::PROTO_ICMP);
    is_dns = is_udp && ((in_data.source_port == name_service_port) ||
                        (in_data.dest_port == name_service_port));
    is_web = is_tcp && ((in_data.source_port == web_port_first) ||
                        (in_data.source_port == web_port_second) ||
                        (in_data.dest_port == web_port_first) ||
                        (in_data.dest_port == web_port_second));
    syn_req = is_tcp && in_data.tcp_flag_bits[pst_pkg::SYN_BIT];
    web_req = is_web;
    syn_key = in_data.source_addr;
    web_key = in_data.dest_addr;
    syn_amount = 32'd1;
    if (in_data.frame_length > 16'(pst_pkg::HEADER_BYTES)) begin
      web_amount = {16'd0, in_data.frame_length - 16'(pst_pkg::HEADER_BYTES)};
    end else begin
      web_amount = 32'd0;
    end
    cfg_ready = !rst;
    out_free = !out_valid || out_ready;
  end

  // Configuration registers and saturating counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      web_port_first <= pst_pkg::WEB_PORT_FIRST_RESET;
      web_port_second <= pst_pkg::WEB_PORT_SECOND_RESET;
      name_service_port <= pst_pkg::NAME_SERVICE_PORT_RESET;
      icmp_cnt <= '0;
      tcp_cnt <= '0;
      udp_cnt <= '0;
      dns_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (pst_pkg::cfg_index_t'(cfg_index))
          pst_pkg::CFG_WEB_PORT_FIRST: web_port_first <= cfg_data;
          pst_pkg::CFG_WEB_PORT_SECOND: web_port_second <= cfg_data;
          pst_pkg::CFG_NAME_SERVICE_PORT: name_service_port <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.start) begin
        if (is_icmp && (icmp_cnt != '1)) icmp_cnt <= icmp_cnt + 1'b1;
        if (is_tcp && (tcp_cnt != '1)) tcp_cnt <= tcp_cnt + 1'b1;
        if (is_udp && (udp_cnt != '1)) udp_cnt <= udp_cnt + 1'b1;
        if (is_dns && (dns_cnt != '1)) dns_cnt <= dns_cnt + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.icmp_total <= icmp_cnt;
      out_data.tcp_total <= tcp_cnt;
      out_data.udp_total <= udp_cnt;
      out_data.dns_total <= dns_cnt;
      out_data.top_syn_addr <= syn_res.addr;
      out_data.top_syn_count <= syn_res.value;
      out_data.top_syn_valid <= syn_res.valid;
      out_data.top_web_addr <= web_res.addr;
      out_data.top_web_bytes <= web_res.value;
      out_data.top_web_valid <= web_res.valid;
      out_data.table_overflow <= syn_res.overflow || web_res.overflow;
    end
  end

endmodule

// ===== rtl/core/pst_ctrl.sv =====
// Controller state machine sequencing accept, table scan, update and result.
// Depends on pst_pkg.
module pst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  pst_pkg::ctrl_status_t status,
  output pst_pkg::ctrl_cmd_t    cmd,
  output logic                 in_ready
);

  pst_pkg::state_t state;
  pst_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      pst_pkg::ST_IDLE: begin
        // No request is taken while reset is held.
        in_ready = !rst;
        if (status.in_valid && !rst) begin
          cmd.start = 1'b1;
          state_next = pst_pkg::ST_SCAN;
        end
      end
      pst_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.syn_done && status.web_done) begin
          state_next = pst_pkg::ST_READ;
        end
      end
      pst_pkg::ST_READ: begin
        // The value memory read at the found entry completes here.
        state_next = pst_pkg::ST_WRITE;
      end
      pst_pkg::ST_WRITE: begin
        cmd.upd_write = 1'b1;
        state_next = pst_pkg::ST_FINISH;
      end
      pst_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next = pst_pkg::ST_IDLE;
        end
      end
      default: state_next = pst_pkg::ST_IDLE;
    endcase
  end

endmodule
